FILE: hdl/ihex_pkg.sv
// Shared types and codes for the Intel HEX record parser.
// Used by ihex_front, ihex_back and the top level; no dependencies.
package ihex_pkg;

  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  localparam int unsigned CHAR_Q_DEPTH = 2;
  localparam int unsigned RES_Q_DEPTH  = 2;

  localparam logic [2:0] KIND_DATA   = 3'd0;
  localparam logic [2:0] KIND_ACCEPT = 3'd1;
  localparam logic [2:0] KIND_SKIP   = 3'd2;
  localparam logic [2:0] KIND_EOF    = 3'd3;
  localparam logic [2:0] KIND_ERROR  = 3'd4;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_START     = 3'd1;
  localparam logic [2:0] ERR_HEADER    = 3'd2;
  localparam logic [2:0] ERR_DATA      = 3'd3;
  localparam logic [2:0] ERR_CHECK_DIG = 3'd4;
  localparam logic [2:0] ERR_MISMATCH  = 3'd5;
  localparam logic [2:0] ERR_TYPE      = 3'd6;

  localparam logic [7:0] REC_DATA     = 8'd0;
  localparam logic [7:0] REC_EOF      = 8'd1;
  localparam logic [7:0] REC_LAST_SKIP = 8'd5;

  // One classified character, as handed from front to back.
  typedef struct packed {
    logic       is_hex;
    logic [3:0] nibble;
    logic       is_colon;
    logic       is_newline;
  } ihex_char_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  error_code;
    logic [15:0] record_address;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    logic [15:0] line_number;
  } ihex_result_t;

endpackage

FILE: hdl/ihex_front.sv
// Front end: takes characters, decodes hex digits and markers, and queues them.
// Depends on ihex_pkg.
module ihex_front
  import ihex_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_ch,
  output logic       in_full,
  output logic       chr_valid,
  output ihex_char_t chr_data,
  input  logic       chr_take
);

  localparam int unsigned PTR_W = $clog2(CHAR_Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(CHAR_Q_DEPTH + 1);

  ihex_char_t             q_r [CHAR_Q_DEPTH];
  logic [PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  ihex_char_t             cls;
  logic                   push_ok;
  logic                   pop_ok;

  always_comb begin
    cls            = '0;
    cls.is_colon   = (in_ch == CHAR_COLON);
    cls.is_newline = (in_ch == CHAR_NEWLINE);
    if (in_ch >= 8'h30 && in_ch <= 8'h39) begin
      cls.is_hex = 1'b1;
      cls.nibble = 4'(in_ch - 8'h30);
    end else if (in_ch >= 8'h61 && in_ch <= 8'h66) begin
      cls.is_hex = 1'b1;
      cls.nibble = 4'(in_ch - 8'h57);
    end else if (in_ch >= 8'h41 && in_ch <= 8'h46) begin
      cls.is_hex = 1'b1;
      cls.nibble = 4'(in_ch - 8'h37);
    end
  end

  assign in_full   = (cnt_r == CNT_W'(CHAR_Q_DEPTH));
  assign push_ok   = in_push & ~in_full;
  assign chr_valid = (cnt_r != '0);
  assign chr_data  = q_r[rd_ptr_r];
  assign pop_ok    = chr_take & chr_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CHAR_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CHAR_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

FILE: hdl/ihex_back.sv
// Back end: record parser state machine and the result queue it fills.
// Depends on ihex_pkg; fed by ihex_front.
module ihex_back
  import ihex_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         chr_valid,
  input  ihex_char_t   chr_data,
  output logic         chr_take,
  output logic         res_empty,
  output ihex_result_t res_data,
  input  logic         res_pop
);

  typedef enum logic [2:0] {
    PH_START,
    PH_HEADER,
    PH_DATA,
    PH_CHECK,
    PH_TAIL
  } phase_t;

  localparam int unsigned PTR_W = $clog2(RES_Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(RES_Q_DEPTH + 1);

  phase_t      phase_r, phase_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [2:0]  digit_pos_r, digit_pos_nxt;
  logic [7:0]  byte_count_r, byte_count_nxt;
  logic [15:0] load_address_r, load_address_nxt;
  logic [7:0]  record_kind_r, record_kind_nxt;
  logic [7:0]  running_sum_r, running_sum_nxt;
  logic [7:0]  bytes_done_r, bytes_done_nxt;
  logic [15:0] line_counter_r, line_counter_nxt;
  logic        halted_r, halted_nxt;

  ihex_result_t     q_r [RES_Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic         res_full;
  logic         res_valid;
  ihex_result_t res;
  logic [7:0]   value;
  logic [7:0]   kind_new;
  logic [7:0]   bytes_inc;
  logic         pop_ok;
  logic         push_ok;

  assign res_full = (cnt_r == CNT_W'(RES_Q_DEPTH));
  assign chr_take = chr_valid & ~res_full;
  assign value    = {high_nibble_r, chr_data.nibble};
  assign kind_new = {record_kind_r[3:0], chr_data.nibble};
  assign bytes_inc = bytes_done_r + 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    high_nibble_nxt  = high_nibble_r;
    digit_pos_nxt    = digit_pos_r;
    byte_count_nxt   = byte_count_r;
    load_address_nxt = load_address_r;
    record_kind_nxt  = record_kind_r;
    running_sum_nxt  = running_sum_r;
    bytes_done_nxt   = bytes_done_r;
    line_counter_nxt = line_counter_r;
    halted_nxt       = halted_r;
    res_valid        = 1'b0;
    res              = '0;
    res.record_address = load_address_r;
    res.line_number    = line_counter_r;
    if (chr_take && !halted_r) begin
      case (phase_r)
        PH_START: begin
          if (!chr_data.is_colon) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_START;
            res.byte_index = bytes_done_r;
          end else begin
            phase_nxt        = PH_HEADER;
            digit_pos_nxt    = '0;
            byte_count_nxt   = '0;
            load_address_nxt = '0;
            record_kind_nxt  = '0;
            running_sum_nxt  = '0;
            bytes_done_nxt   = '0;
            high_nibble_nxt  = '0;
          end
        end
        PH_HEADER: begin
          if (!chr_data.is_hex) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_HEADER;
            res.byte_index = bytes_done_r;
          end else if (digit_pos_r < 3'd2) begin
            byte_count_nxt = {byte_count_r[3:0], chr_data.nibble};
            digit_pos_nxt  = digit_pos_r + 3'd1;
          end else if (digit_pos_r < 3'd6) begin
            load_address_nxt = {load_address_r[11:0], chr_data.nibble};
            digit_pos_nxt    = digit_pos_r + 3'd1;
          end else if (digit_pos_r == 3'd6) begin
            record_kind_nxt = kind_new;
            digit_pos_nxt   = digit_pos_r + 3'd1;
          end else begin
            // last type digit: header complete
            record_kind_nxt = kind_new;
            digit_pos_nxt   = '0;
            running_sum_nxt = byte_count_r + load_address_r[7:0]
                              + load_address_r[15:8] + kind_new;
            res.byte_index  = byte_count_r;
            if (kind_new == REC_DATA) begin
              phase_nxt = (byte_count_r == 8'd0) ? PH_CHECK : PH_DATA;
            end else if (kind_new == REC_EOF) begin
              halted_nxt = 1'b1;
              res_valid  = 1'b1;
              res.kind   = KIND_EOF;
            end else if (kind_new <= REC_LAST_SKIP) begin
              phase_nxt = PH_TAIL;
              res_valid = 1'b1;
              res.kind  = KIND_SKIP;
            end else begin
              halted_nxt     = 1'b1;
              res_valid      = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_TYPE;
              res.byte_index = bytes_done_r;
            end
          end
        end
        PH_DATA: begin
          if (!chr_data.is_hex) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_DATA;
            res.byte_index = bytes_done_r;
          end else if (digit_pos_r == 3'd0) begin
            high_nibble_nxt = chr_data.nibble;
            digit_pos_nxt   = 3'd1;
          end else begin
            digit_pos_nxt   = '0;
            running_sum_nxt = running_sum_r + value;
            bytes_done_nxt  = bytes_inc;
            if (bytes_inc == byte_count_r) begin
              phase_nxt = PH_CHECK;
            end
            res_valid      = 1'b1;
            res.kind       = KIND_DATA;
            res.data_byte  = value;
            res.byte_index = bytes_done_r;
          end
        end
        PH_CHECK: begin
          if (!chr_data.is_hex) begin
            halted_nxt     = 1'b1;
            res_valid      = 1'b1;
            res.kind       = KIND_ERROR;
            res.error_code = ERR_CHECK_DIG;
            res.byte_index = bytes_done_r;
          end else if (digit_pos_r == 3'd0) begin
            high_nibble_nxt = chr_data.nibble;
            digit_pos_nxt   = 3'd1;
          end else begin
            digit_pos_nxt = '0;
            res_valid     = 1'b1;
            if (8'(running_sum_r + value) != 8'd0) begin
              halted_nxt     = 1'b1;
              res.kind       = KIND_ERROR;
              res.error_code = ERR_MISMATCH;
              res.byte_index = bytes_done_r;
            end else begin
              phase_nxt      = PH_TAIL;
              res.kind       = KIND_ACCEPT;
              res.byte_index = byte_count_r;
            end
          end
        end
        PH_TAIL: begin
          if (chr_data.is_newline) begin
            if (line_counter_r != 16'hFFFF) begin
              line_counter_nxt = line_counter_r + 16'd1;
            end
            phase_nxt = PH_START;
          end
        end
        default: begin
          phase_nxt = PH_START;
        end
      endcase
    end
  end

  // result queue
  assign push_ok   = res_valid;
  assign res_empty = (cnt_r == '0);
  assign res_data  = q_r[rd_ptr_r];
  assign pop_ok    = res_pop & ~res_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_ok) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_ok) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(RES_Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_ok && !pop_ok) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push_ok && pop_ok) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_START;
      high_nibble_r  <= '0;
      digit_pos_r    <= '0;
      byte_count_r   <= '0;
      load_address_r <= '0;
      record_kind_r  <= '0;
      running_sum_r  <= '0;
      bytes_done_r   <= '0;
      line_counter_r <= 16'd1;
      halted_r       <= 1'b0;
      wr_ptr_r       <= '0;
      rd_ptr_r       <= '0;
      cnt_r          <= '0;
    end else begin
      phase_r        <= phase_nxt;
      high_nibble_r  <= high_nibble_nxt;
      digit_pos_r    <= digit_pos_nxt;
      byte_count_r   <= byte_count_nxt;
      load_address_r <= load_address_nxt;
      record_kind_r  <= record_kind_nxt;
      running_sum_r  <= running_sum_nxt;
      bytes_done_r   <= bytes_done_nxt;
      line_counter_r <= line_counter_nxt;
      halted_r       <= halted_nxt;
      wr_ptr_r       <= wr_ptr_nxt;
      rd_ptr_r       <= rd_ptr_nxt;
      cnt_r          <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

FILE: hdl/intel_hex_record_parser_core.sv
// Intel HEX record parser: one ASCII character per transfer in, at most one
// result per character out. A two-entry character queue in the front end
// decodes digits; the back end runs the record state machine and fills a
// two-entry result queue. One character is taken every cycle while input
// arrives and the result side keeps popping; a result enters the result queue
// as the back end takes its character, ready to be popped at the next edge.
// After end of file or an error the block drops every character until reset.
// Depends on ihex_pkg, ihex_front and ihex_back.
module intel_hex_record_parser_core
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic [7:0]  in_ch,
  output logic        full,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_kind,
  output logic [2:0]  out_error_code,
  output logic [15:0] out_record_address,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_byte_index,
  output logic [15:0] out_line_number
);

  logic         chr_valid;
  ihex_char_t   chr_data;
  logic         chr_take;
  ihex_result_t res_data;

  ihex_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_ch     (in_ch),
    .in_full   (full),
    .chr_valid (chr_valid),
    .chr_data  (chr_data),
    .chr_take  (chr_take)
  );

  ihex_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .chr_valid (chr_valid),
    .chr_data  (chr_data),
    .chr_take  (chr_take),
    .res_empty (empty),
    .res_data  (res_data),
    .res_pop   (pop)
  );

  assign out_kind           = res_data.kind;
  assign out_error_code     = res_data.error_code;
  assign out_record_address = res_data.record_address;
  assign out_data_byte      = res_data.data_byte;
  assign out_byte_index     = res_data.byte_index;
  assign out_line_number    = res_data.line_number;

endmodule
